// File: sv/rgbhsv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RGB to HSV converter package
// Channel width, divider widths and the state carried along the divider chain.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

    localparam int CHANNEL_BITS = 16;
    localparam int HUE_BITS     = CHANNEL_BITS + 3;

    typedef logic [CHANNEL_BITS-1:0] t_channel;
    typedef logic [HUE_BITS-1:0]     t_hue_word;

    typedef struct packed {
        t_hue_word hue_den;
        t_hue_word hue_rem;
        t_channel  hue_q;
        t_channel  sat_den;
        t_channel  sat_rem;
        t_channel  sat_low;
        t_channel  sat_q;
        t_channel  bright;
    } t_div_state;

endpackage
`default_nettype wire

// File: sv/rgbhsv_pix_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Pixel request channel
// Valid/ready channel that carries one RGB pixel.
// ----------------------------------------------------------------------------
interface rgbhsv_pix_if;

    logic                 valid;
    logic                 ready;
    rgbhsv_pkg::t_channel red_level;
    rgbhsv_pkg::t_channel green_level;
    rgbhsv_pkg::t_channel blue_level;

    modport source (output valid, output red_level, output green_level,
                    output blue_level, input ready);
    modport sink   (input valid, input red_level, input green_level,
                    input blue_level, output ready);

endinterface
`default_nettype wire

// File: sv/rgbhsv_hsv_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// HSV result channel
// Valid/ready channel that carries one hue, saturation, brightness triple.
// ----------------------------------------------------------------------------
interface rgbhsv_hsv_if;

    logic                 valid;
    logic                 ready;
    rgbhsv_pkg::t_channel hue_turn;
    rgbhsv_pkg::t_channel saturation_level;
    rgbhsv_pkg::t_channel brightness_level;

    modport source (output valid, output hue_turn, output saturation_level,
                    output brightness_level, input ready);
    modport sink   (input valid, input hue_turn, input saturation_level,
                    input brightness_level, output ready);

endinterface
`default_nettype wire

// File: sv/rgbhsv_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RGB to HSV front end
// Two stages: pick maximum and minimum, then build hue numerator, divisors
// and the saturation dividend that seed the divider chain.
// ----------------------------------------------------------------------------
module rgbhsv_front (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    input  wire rgbhsv_pkg::t_channel   i_red,
    input  wire rgbhsv_pkg::t_channel   i_green,
    input  wire rgbhsv_pkg::t_channel   i_blue,
    input  wire logic                   i_adv,
    output logic                        o_adv,
    output logic                        o_valid,
    output rgbhsv_pkg::t_div_state      o_state
);

    localparam int CB = rgbhsv_pkg::CHANNEL_BITS;
    localparam int HB = rgbhsv_pkg::HUE_BITS;

    typedef enum logic [1:0] {SEL_RED, SEL_GREEN, SEL_BLUE} t_max_sel;

    logic                 r_valid1;
    rgbhsv_pkg::t_channel r_red;
    rgbhsv_pkg::t_channel r_green;
    rgbhsv_pkg::t_channel r_blue;
    rgbhsv_pkg::t_channel r_max;
    rgbhsv_pkg::t_channel r_min;
    t_max_sel             r_sel;

    rgbhsv_pkg::t_channel n_max;
    rgbhsv_pkg::t_channel n_min;
    t_max_sel             n_sel;

    logic                   r_valid2;
    rgbhsv_pkg::t_div_state r_state;
    rgbhsv_pkg::t_div_state n_state;

    logic                   adv1;
    logic                   adv2;
    rgbhsv_pkg::t_channel   spread;
    rgbhsv_pkg::t_hue_word  six;
    rgbhsv_pkg::t_hue_word  num;
    logic [2*CB-1:0]        dividend;

    assign adv2  = !r_valid2 || i_adv;
    assign adv1  = !r_valid1 || adv2;
    assign o_adv = adv1;

    always_comb begin
        if (i_red >= i_green && i_red >= i_blue) begin
            n_sel = SEL_RED;
            n_max = i_red;
        end else if (i_green >= i_blue) begin
            n_sel = SEL_GREEN;
            n_max = i_green;
        end else begin
            n_sel = SEL_BLUE;
            n_max = i_blue;
        end
        n_min = i_red;
        if (i_green < n_min) n_min = i_green;
        if (i_blue < n_min)  n_min = i_blue;
    end

    always_comb begin
        spread   = r_max - r_min;
        six      = HB'({spread, 2'b00}) + HB'({spread, 1'b0});
        dividend = {spread, {CB{1'b0}}} - {{CB{1'b0}}, spread};
        unique case (r_sel)
            SEL_RED: begin
                if (r_green >= r_blue) begin
                    num = HB'(r_green - r_blue);
                end else begin
                    num = six - HB'(r_blue - r_green);
                end
            end
            SEL_GREEN: num = HB'(r_blue) + HB'({spread, 1'b0}) - HB'(r_red);
            SEL_BLUE:  num = HB'(r_red) + HB'({spread, 2'b00}) - HB'(r_green);
            default:   num = '0;
        endcase
        n_state.hue_den = (spread == '0) ? HB'(1) : six;
        n_state.hue_rem = num;
        n_state.hue_q   = '0;
        n_state.sat_den = (r_max == '0) ? CB'(1) : r_max;
        n_state.sat_rem = dividend[2*CB-1:CB];
        n_state.sat_low = dividend[CB-1:0];
        n_state.sat_q   = '0;
        n_state.bright  = r_max;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
            r_valid2 <= 1'b0;
        end else begin
            if (adv1) r_valid1 <= i_valid;
            if (adv2) r_valid2 <= r_valid1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_red   <= i_red;
            r_green <= i_green;
            r_blue  <= i_blue;
            r_max   <= n_max;
            r_min   <= n_min;
            r_sel   <= n_sel;
        end
        if (adv2) r_state <= n_state;
    end

    assign o_valid = r_valid2;
    assign o_state = r_state;

endmodule
`default_nettype wire

// File: sv/rgbhsv_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RGB to HSV divider cell
// One restoring step of both the hue and the saturation division.
// ----------------------------------------------------------------------------
module rgbhsv_cell (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    input  wire rgbhsv_pkg::t_div_state i_state,
    input  wire logic                   i_adv,
    output logic                        o_adv,
    output logic                        o_valid,
    output rgbhsv_pkg::t_div_state      o_state
);

    localparam int CB = rgbhsv_pkg::CHANNEL_BITS;
    localparam int HB = rgbhsv_pkg::HUE_BITS;

    logic                   r_valid;
    rgbhsv_pkg::t_div_state r_state;
    rgbhsv_pkg::t_div_state n_state;
    logic [HB:0]            hue_try;
    logic [CB:0]            sat_try;

    assign o_adv = !r_valid || i_adv;

    always_comb begin
        n_state = i_state;
        hue_try = {i_state.hue_rem, 1'b0};
        if (hue_try >= {1'b0, i_state.hue_den}) begin
            n_state.hue_rem = HB'(hue_try - {1'b0, i_state.hue_den});
            n_state.hue_q   = {i_state.hue_q[CB-2:0], 1'b1};
        end else begin
            n_state.hue_rem = hue_try[HB-1:0];
            n_state.hue_q   = {i_state.hue_q[CB-2:0], 1'b0};
        end
        sat_try         = {i_state.sat_rem, i_state.sat_low[CB-1]};
        n_state.sat_low = {i_state.sat_low[CB-2:0], 1'b0};
        if (sat_try >= {1'b0, i_state.sat_den}) begin
            n_state.sat_rem = CB'(sat_try - {1'b0, i_state.sat_den});
            n_state.sat_q   = {i_state.sat_q[CB-2:0], 1'b1};
        end else begin
            n_state.sat_rem = sat_try[CB-1:0];
            n_state.sat_q   = {i_state.sat_q[CB-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) r_state <= n_state;
    end

    assign o_valid = r_valid;
    assign o_state = r_state;

endmodule
`default_nettype wire

// File: sv/rgb_to_hsv_converter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RGB to HSV converter
// Converts a stream of RGB pixels into hue, saturation and brightness.
// ----------------------------------------------------------------------------
// i_pix is the pixel request channel, o_hsv the result channel; a request
// moves on a clock edge with valid and ready both high.
// Two front stages find maximum and minimum and build the numerators, then
// a row of CHANNEL_BITS divider cells produces one quotient bit of hue and
// of saturation per cell. A result is registered in both front stages and
// then in every cell in turn; it is valid once the last cell holds it and
// leaves at an edge with o_hsv.ready high.
// With o_hsv.ready high every stage moves on each cycle: one pixel per cycle.
// Each stage advances when it is empty or its successor advances, so a
// stalled o_hsv fills the empty stages first and i_pix.ready drops only
// once every stage holds a request. Results stay in order, none dropped.
// Synchronous active-low reset empties all stages; payload is not cleared.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    rgbhsv_pix_if.sink   i_pix,
    rgbhsv_hsv_if.source o_hsv
);

    localparam int CB = rgbhsv_pkg::CHANNEL_BITS;

    logic                   vld [CB+1];
    logic                   adv [CB+1];
    rgbhsv_pkg::t_div_state dat [CB+1];

    rgbhsv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_pix.valid),
        .i_red   (i_pix.red_level),
        .i_green (i_pix.green_level),
        .i_blue  (i_pix.blue_level),
        .i_adv   (adv[0]),
        .o_adv   (i_pix.ready),
        .o_valid (vld[0]),
        .o_state (dat[0])
    );

    for (genvar k = 0; k < CB; k++) begin : g_cell
        rgbhsv_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (vld[k]),
            .i_state (dat[k]),
            .i_adv   (adv[k+1]),
            .o_adv   (adv[k]),
            .o_valid (vld[k+1]),
            .o_state (dat[k+1])
        );
    end

    assign adv[CB]                = o_hsv.ready;
    assign o_hsv.valid            = vld[CB];
    assign o_hsv.hue_turn         = dat[CB].hue_q;
    assign o_hsv.saturation_level = dat[CB].sat_q;
    assign o_hsv.brightness_level = dat[CB].bright;

`ifndef SYNTHESIS
    a_zero_bright_zero_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_hsv.valid && o_hsv.brightness_level == '0) |-> o_hsv.saturation_level == '0)
        else $error("saturation nonzero for black pixel");

    a_hue_needs_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_hsv.valid && o_hsv.hue_turn != '0) |-> o_hsv.saturation_level != '0)
        else $error("hue nonzero for gray pixel");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_hsv.valid)
        else $error("result valid right after reset");
`endif

endmodule
`default_nettype wire
